// File: hdl/lisf_pkg.sv
// shared types and status codes for the line intersection block
// no dependencies
package lisf_pkg;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_PAR = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef struct packed {
    logic par;
    logic dv;
    logic negq;
  } lisf_flags_t;

endpackage

// File: hdl/lisf_if.sv
// request and result channel interfaces
// depends on nothing; width set by parameter W
interface lisf_in_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic         a_vertical;
  logic [W-1:0] a_slope;
  logic [W-1:0] a_offset;
  logic         b_vertical;
  logic [W-1:0] b_slope;
  logic [W-1:0] b_offset;
  modport source (output valid, a_vertical, a_slope, a_offset, b_vertical, b_slope, b_offset,
                  input ready);
  modport sink (input valid, a_vertical, a_slope, a_offset, b_vertical, b_slope, b_offset,
                output ready);
endinterface

interface lisf_out_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] cross_x;
  logic [W-1:0] cross_y;
  logic [1:0]   status;
  modport source (output valid, cross_x, cross_y, status, input ready);
  modport sink (input valid, cross_x, cross_y, status, output ready);
endinterface

// File: hdl/line_intersection_slope_form.sv
// top level: line pair intersection in signed fixed point, fully pipelined
// depends on lisf_pkg, lisf_if, lisf_div_step, lisf_tail
//
// channel    dir  handshake     payload
// in_chan    in   valid/ready   a_vertical a_slope a_offset b_vertical b_slope b_offset
// out_chan   out  valid/ready   cross_x cross_y status
//
// one request per cycle while the result side is not stalled; a request passes an entry stage,
// the one-bit-per-stage divider chain, then the x, multiply and y stages
// synchronous active-low reset clears all stage valid bits
// a stalled result holds every stage in place; nothing is dropped or repeated
module line_intersection_slope_form #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input logic           clk,
  input logic           rst_n,
  lisf_in_if.sink       in_chan,
  lisf_out_if.source    out_chan
);
  import lisf_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NB = W + 1 + F;

  logic en;

  logic signed [W:0] num, den;
  logic [W:0]        anum, aden;
  lisf_flags_t       flags_nxt;

  logic         valid_s [NB+1];
  lisf_flags_t  flags_s [NB+1];
  logic [W-1:0] m_s     [NB+1];
  logic [W-1:0] b_s     [NB+1];
  logic [W-1:0] xv_s    [NB+1];
  logic [W:0]   d_s     [NB+1];
  logic [W-1:0] rem_s   [NB+1];
  logic [NB-1:0] nq_s   [NB+1];

  logic         e_valid_r;
  lisf_flags_t  e_flags_r;
  logic [W-1:0] e_m_r, e_b_r, e_xv_r;
  logic [W:0]   e_d_r;
  logic [NB-1:0] e_nq_r;

  assign en = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = en;

  assign num = $signed({in_chan.b_offset[W-1], in_chan.b_offset})
             - $signed({in_chan.a_offset[W-1], in_chan.a_offset});
  assign den = $signed({in_chan.a_slope[W-1], in_chan.a_slope})
             - $signed({in_chan.b_slope[W-1], in_chan.b_slope});
  assign anum = num[W] ? (~num + 1'b1) : num;
  assign aden = den[W] ? (~den + 1'b1) : den;

  always_comb begin
    flags_nxt.par  = (in_chan.a_vertical && in_chan.b_vertical)
                  || (!in_chan.a_vertical && !in_chan.b_vertical
                      && in_chan.a_slope == in_chan.b_slope);
    flags_nxt.dv   = !in_chan.a_vertical && !in_chan.b_vertical && !flags_nxt.par;
    flags_nxt.negq = num[W] ^ den[W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (en) begin
      e_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_flags_r <= flags_nxt;
      e_m_r     <= in_chan.a_vertical ? in_chan.b_slope  : in_chan.a_slope;
      e_b_r     <= in_chan.a_vertical ? in_chan.b_offset : in_chan.a_offset;
      e_xv_r    <= in_chan.a_vertical ? in_chan.a_offset : in_chan.b_offset;
      e_d_r     <= aden;
      e_nq_r    <= {anum, {F{1'b0}}};
    end
  end

  assign valid_s[0] = e_valid_r;
  assign flags_s[0] = e_flags_r;
  assign m_s[0]     = e_m_r;
  assign b_s[0]     = e_b_r;
  assign xv_s[0]    = e_xv_r;
  assign d_s[0]     = e_d_r;
  assign rem_s[0]   = '0;
  assign nq_s[0]    = e_nq_r;

  for (genvar i = 0; i < NB; i++) begin : g_div
    lisf_div_step #(.W(W), .NB(NB)) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (valid_s[i]),
      .flags_i (flags_s[i]),
      .m_i     (m_s[i]),
      .b_i     (b_s[i]),
      .xv_i    (xv_s[i]),
      .d_i     (d_s[i]),
      .rem_i   (rem_s[i]),
      .nq_i    (nq_s[i]),
      .valid_o (valid_s[i+1]),
      .flags_o (flags_s[i+1]),
      .m_o     (m_s[i+1]),
      .b_o     (b_s[i+1]),
      .xv_o    (xv_s[i+1]),
      .d_o     (d_s[i+1]),
      .rem_o   (rem_s[i+1]),
      .nq_o    (nq_s[i+1])
    );
  end

  lisf_tail #(.W(W), .F(F), .NB(NB)) u_tail (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (valid_s[NB]),
    .flags_i (flags_s[NB]),
    .m_i     (m_s[NB]),
    .b_i     (b_s[NB]),
    .xv_i    (xv_s[NB]),
    .q_i     (nq_s[NB]),
    .valid_o (out_chan.valid),
    .x_o     (out_chan.cross_x),
    .y_o     (out_chan.cross_y),
    .st_o    (out_chan.status)
  );
endmodule

// File: hdl/lisf_div_step.sv
// one registered restoring division step, payload carried alongside
// depends on lisf_pkg
module lisf_div_step #(
  parameter int W  = 32,
  parameter int NB = 49
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  lisf_pkg::lisf_flags_t flags_i,
  input  logic [W-1:0]         m_i,
  input  logic [W-1:0]         b_i,
  input  logic [W-1:0]         xv_i,
  input  logic [W:0]           d_i,
  input  logic [W-1:0]         rem_i,
  input  logic [NB-1:0]        nq_i,
  output logic                 valid_o,
  output lisf_pkg::lisf_flags_t flags_o,
  output logic [W-1:0]         m_o,
  output logic [W-1:0]         b_o,
  output logic [W-1:0]         xv_o,
  output logic [W:0]           d_o,
  output logic [W-1:0]         rem_o,
  output logic [NB-1:0]        nq_o
);
  import lisf_pkg::*;

  logic         valid_r;
  lisf_flags_t  flags_r;
  logic [W-1:0] m_r, b_r, xv_r, rem_r;
  logic [W:0]   d_r;
  logic [NB-1:0] nq_r;
  logic [W:0]   trial, diff;
  logic         ge;

  assign trial = {rem_i, nq_i[NB-1]};
  assign ge    = trial >= d_i;
  assign diff  = trial - d_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_r <= flags_i;
      m_r     <= m_i;
      b_r     <= b_i;
      xv_r    <= xv_i;
      d_r     <= d_i;
      rem_r   <= ge ? diff[W-1:0] : trial[W-1:0];
      nq_r    <= {nq_i[NB-2:0], ge};
    end
  end

  assign valid_o = valid_r;
  assign flags_o = flags_r;
  assign m_o     = m_r;
  assign b_o     = b_r;
  assign xv_o    = xv_r;
  assign d_o     = d_r;
  assign rem_o   = rem_r;
  assign nq_o    = nq_r;
endmodule

// File: hdl/lisf_tail.sv
// x saturation, slope multiply and y finish, three register stages
// depends on lisf_pkg
module lisf_tail #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int NB = 49
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  lisf_pkg::lisf_flags_t flags_i,
  input  logic [W-1:0]         m_i,
  input  logic [W-1:0]         b_i,
  input  logic [W-1:0]         xv_i,
  input  logic [NB-1:0]        q_i,
  output logic                 valid_o,
  output logic [W-1:0]         x_o,
  output logic [W-1:0]         y_o,
  output logic [1:0]           st_o
);
  import lisf_pkg::*;

  // x stage
  logic         xs_valid_r, xs_par_r, xs_sat_r;
  logic [W-1:0] xs_x_r, xs_m_r, xs_b_r;
  logic         pos_ov, neg_ov;
  logic [W-1:0] x_nxt;
  logic         sat_nxt;

  // multiply stage
  logic            ms_valid_r, ms_par_r, ms_sat_r;
  logic [W-1:0]    ms_x_r, ms_b_r;
  logic [2*W-1:0]  ms_p_r;

  // y stage
  logic            ys_valid_r;
  logic [W-1:0]    ys_x_r, ys_y_r;
  logic [1:0]      ys_st_r;
  logic signed [2*W-1:0] psh;
  logic signed [2*W:0]   ysum;
  logic            y_ov;
  logic [W-1:0]    y_nxt;

  assign pos_ov = |q_i[NB-1:W-1];
  assign neg_ov = (|q_i[NB-1:W]) || (q_i[W-1] && (|q_i[W-2:0]));

  always_comb begin
    x_nxt   = xv_i;
    sat_nxt = 1'b0;
    if (flags_i.dv) begin
      if (flags_i.negq) begin
        sat_nxt = neg_ov;
        x_nxt   = neg_ov ? {1'b1, {(W-1){1'b0}}} : (~q_i[W-1:0] + 1'b1);
      end else begin
        sat_nxt = pos_ov;
        x_nxt   = pos_ov ? {1'b0, {(W-1){1'b1}}} : q_i[W-1:0];
      end
    end
  end

  assign psh  = $signed(ms_p_r) >>> F;
  assign ysum = {psh[2*W-1], psh} + $signed({{(W+1){ms_b_r[W-1]}}, ms_b_r});
  assign y_ov = !((&ysum[2*W:W-1]) || (~|ysum[2*W:W-1]));
  assign y_nxt = y_ov ? (ysum[2*W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                      : ysum[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xs_valid_r <= 1'b0;
      ms_valid_r <= 1'b0;
      ys_valid_r <= 1'b0;
    end else if (en) begin
      xs_valid_r <= valid_i;
      ms_valid_r <= xs_valid_r;
      ys_valid_r <= ms_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs_par_r <= flags_i.par;
      xs_sat_r <= sat_nxt;
      xs_x_r   <= x_nxt;
      xs_m_r   <= m_i;
      xs_b_r   <= b_i;

      ms_par_r <= xs_par_r;
      ms_sat_r <= xs_sat_r;
      ms_x_r   <= xs_x_r;
      ms_b_r   <= xs_b_r;
      ms_p_r   <= $signed(xs_m_r) * $signed(xs_x_r);

      ys_x_r   <= ms_par_r ? '0 : ms_x_r;
      ys_y_r   <= ms_par_r ? '0 : y_nxt;
      ys_st_r  <= ms_par_r ? ST_PAR : ((ms_sat_r || y_ov) ? ST_SAT : ST_OK);
    end
  end

  assign valid_o = ys_valid_r;
  assign x_o     = ys_x_r;
  assign y_o     = ys_y_r;
  assign st_o    = ys_st_r;
endmodule

// File: hdl/lisf_checker.sv
// port-level checks on the result channel, bound to the top level
// depends on lisf_pkg and line_intersection_slope_form
module lisf_checker #(
  parameter int W = 32
) (
  input logic         clk,
  input logic         rst_n,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] out_cross_x,
  input logic [W-1:0] out_cross_y,
  input logic [1:0]   out_status
);
  import lisf_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_cross_x) && $stable(out_cross_y)
                               && $stable(out_status))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_PAR || out_status == ST_SAT))
    else $error("bad status code");

  a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_PAR |-> out_cross_x == '0 && out_cross_y == '0)
    else $error("parallel result carries a point");
endmodule

bind line_intersection_slope_form lisf_checker #(.W(WORD_BITS)) u_lisf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_cross_x (out_chan.cross_x),
  .out_cross_y (out_chan.cross_y),
  .out_status  (out_chan.status)
);

// File: test/tb_line_intersection_slope_form.sv
// testbench for the line intersection block: random and directed line pairs
// depends on lisf_pkg, lisf_if and the line_intersection_slope_form rtl
module tb_line_intersection_slope_form;
  import lisf_pkg::*;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [1:0]  st;
  } point_t;

  class point_board;
    point_t pending[$];
    int errors = 0;
    int checked = 0;
    int par_seen = 0;
    int sat_seen = 0;

    function void note(point_t p);
      pending.push_back(p);
    endfunction

    function void check(logic [31:0] x, logic [31:0] y, logic [1:0] st);
      point_t e;
      if (pending.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (st == ST_PAR) par_seen++;
      if (st == ST_SAT) sat_seen++;
      if (x !== e.x) begin
        $error("cross_x expected %h actual %h", e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $error("cross_y expected %h actual %h", e.y, y);
        errors++;
      end
      if (st !== e.st) begin
        $error("status expected %0d actual %0d", e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  always #5 clk = ~clk;

  lisf_in_if  #(.W(32)) in_chan ();
  lisf_out_if #(.W(32)) out_chan ();

  line_intersection_slope_form dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  point_board board = new();
  bit hold_sink = 0;
  bit done = 0;

  function automatic logic signed [127:0] clamp32(logic signed [127:0] v, ref bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1;
      return 128'sd2147483647;
    end
    if (v < -128'sd2147483648) begin
      sat = 1;
      return -128'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [127:0] y_on_line(logic signed [31:0] m,
      logic signed [31:0] b, logic signed [127:0] x, ref bit sat);
    logic signed [127:0] p;
    p = (128'(m) * x) >>> 16;
    return clamp32(p + 128'(b), sat);
  endfunction

  function automatic point_t cross_point(logic av, logic [31:0] m1, logic [31:0] b1,
      logic bv, logic [31:0] m2, logic [31:0] b2);
    point_t r;
    bit sat;
    logic signed [127:0] num, den, q, x, y;
    logic [127:0] un, ud;
    sat = 0;
    x = 0;
    y = 0;
    r.st = ST_OK;
    if ((av && bv) || (!av && !bv && m1 == m2)) begin
      r.st = ST_PAR;
    end else if (av) begin
      x = 128'($signed(b1));
      y = y_on_line(m2, b2, x, sat);
    end else if (bv) begin
      x = 128'($signed(b2));
      y = y_on_line(m1, b1, x, sat);
    end else begin
      num = 128'($signed(b2)) - 128'($signed(b1));
      den = 128'($signed(m1)) - 128'($signed(m2));
      un = (num < 0 ? -num : num) << 16;
      ud = den < 0 ? -den : den;
      q = $signed(un / ud);
      if ((num < 0) != (den < 0)) q = -q;
      x = clamp32(q, sat);
      y = y_on_line(m1, b1, x, sat);
    end
    if (r.st == ST_OK && sat) r.st = ST_SAT;
    r.x = x[31:0];
    r.y = y[31:0];
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 | $urandom_range(0, 3);
      1: return 32'h7fff_fffc | $urandom_range(0, 3);
      2: return $urandom_range(0, 8) << 16;
      3: return -($urandom_range(0, 8) << 16);
      4: return $signed($urandom_range(0, 4095)) - 2048;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(logic av, logic [31:0] m1, logic [31:0] b1,
      logic bv, logic [31:0] m2, logic [31:0] b2);
    in_chan.valid      <= 1;
    in_chan.a_vertical <= av;
    in_chan.a_slope    <= m1;
    in_chan.a_offset   <= b1;
    in_chan.b_vertical <= bv;
    in_chan.b_slope    <= m2;
    in_chan.b_offset   <= b2;
    do @(posedge clk); while (!in_chan.ready);
    board.note(cross_point(av, m1, b1, bv, m2, b2));
    @(negedge clk);
  endtask

  task automatic send_random();
    logic av, bv;
    logic [31:0] m1, m2;
    av = ($urandom_range(0, 4) == 0);
    bv = ($urandom_range(0, 4) == 0);
    m1 = rand_word();
    m2 = ($urandom_range(0, 9) == 0) ? m1 : rand_word();
    send_request(av, m1, rand_word(), bv, m2, rand_word());
  endtask

  task automatic pause_sender(int n);
    if (n == 0) return;
    in_chan.valid <= 0;
    repeat (n) @(negedge clk);
  endtask

  initial begin
    out_chan.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_sink) out_chan.ready <= 0;
      else out_chan.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready)
        board.check(out_chan.cross_x, out_chan.cross_y, out_chan.status);
    end
  end

  initial begin
    in_chan.valid = 0;
    in_chan.a_vertical = 0;
    in_chan.a_slope = 0;
    in_chan.a_offset = 0;
    in_chan.b_vertical = 0;
    in_chan.b_slope = 0;
    in_chan.b_offset = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: parallel, vertical, crossing, overflow, extremes
    send_request(1, 32'h0, 32'h1_0000, 1, 32'hffff_ffff, 32'h2_0000);
    send_request(0, 32'h1_0000, 32'h0, 0, 32'h1_0000, 32'h0);
    send_request(0, 32'h8000_0000, 32'h7fff_ffff, 0, 32'h8000_0000, 32'h8000_0000);
    send_request(1, 32'hdead_beef, 32'h3_0000, 0, 32'h2_0000, 32'h1_0000);
    send_request(0, 32'h2_0000, 32'h1_0000, 1, 32'h1234_5678, 32'hfffd_0000);
    send_request(0, 32'h1_0000, 32'h0, 0, 32'hffff_0000, 32'h4_0000);
    send_request(0, 32'h0000_0001, 32'h8000_0000, 0, 32'h0, 32'h7fff_ffff);
    send_request(0, 32'h7fff_ffff, 32'h0, 0, 32'h8000_0000, 32'h7fff_ffff);
    send_request(1, 32'h0, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h7fff_ffff);
    send_request(1, 32'h0, 32'h8000_0000, 0, 32'h7fff_ffff, 32'h8000_0000);
    send_request(0, 32'h7fff_ffff, 32'h8000_0000, 1, 32'h0, 32'h8000_0000);
    send_request(0, 32'hffff_ffff, 32'hffff_ffff, 0, 32'h0, 32'h0);
    send_request(0, 32'h0, 32'h0, 0, 32'hffff_ffff, 32'h0);
    // fill the pipe while the result side holds off
    hold_sink = 1;
    fork
      begin
        repeat (150) @(posedge clk);
        hold_sink = 0;
      end
      repeat (120) send_random();
    join
    // drain completely before going on
    pause_sender(1);
    while (board.pending.size() != 0) @(negedge clk);
    repeat (900) begin
      send_random();
      if ($urandom_range(0, 2) == 0) pause_sender(gap_len());
    end
    in_chan.valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("checked %0d results, %0d parallel, %0d saturated",
             board.checked, board.par_seen, board.sat_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
